// ===== rtl/pngse_pkg.sv =====
// shared types, constants and crc helper for the png stored-stream encoder
// used by pngse_ctrl, pngse_dp and the top level
package pngse_pkg;

  localparam int DimW   = 13;
  localparam int ColW   = 15;
  localparam int RawW   = 29;
  localparam int BlkCntW = 14;
  localparam int IdxW   = 6;

  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxHeight = 4096;

  localparam logic [DimW-1:0] RstWidth  = 13'd640;
  localparam logic [DimW-1:0] RstHeight = 13'd480;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegAlpha  = 2'd2;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] Ones32  = 32'hFFFFFFFF;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [16:0] BlockMax = 17'd65535;

  localparam logic [IdxW-1:0] HdrLast = 6'd42;
  localparam logic [IdxW-1:0] BlkLast = 6'd4;
  localparam logic [IdxW-1:0] TrlLast = 6'd19;

  typedef enum logic [3:0] {
    S_IDLE, S_CALC0, S_CALC1, S_CALC2, S_CALC3, S_HDR,
    S_SEL, S_SELP, S_BLK, S_DATA, S_TRL
  } state_t;

  typedef enum logic [2:0] {
    SRC_HDR, SRC_BLK, SRC_FILT, SRC_PIX, SRC_TRL
  } src_t;

  typedef struct packed {
    logic            load_pix;
    logic            load_geom;
    logic            calc_raw;
    logic            calc_blocks;
    logic            calc_len;
    logic            emit;
    src_t            src;
    logic [IdxW-1:0] idx;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic blk_zero;
    logic col_zero;
    logic last_pixel;
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/png_stored_stream_encoder.sv =====
// png encoder with stored deflate blocks: one channel byte in, file bytes out
// a step's first word is registered after S_SEL, or at image start from S_HDR after S_CALC0..S_CALC3
// a row start adds a filter word, a block header 5 words, image start 43 header words, the last
// byte 20 trailer words, all at out_ready; a new byte is taken only after the last one's words are emitted
// reset: synchronous active-low rst_n; config returns to 640 x 480 rgba, stream to image start
// depends on pngse_pkg, pngse_ctrl, pngse_dp
module png_stored_stream_encoder #(
  parameter int MAX_WIDTH  = pngse_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = pngse_pkg::DefMaxHeight
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [pngse_pkg::DimW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_pixel_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_run_end,
  output logic                       out_file_end
);

  pngse_pkg::cmd_t    cmd;
  pngse_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pngse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pngse_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_pixel_byte (in_pixel_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_end   (out_run_end),
    .out_file_end  (out_file_end)
  );

endmodule

// ===== rtl/pngse_ctrl.sv =====
// sequencer for the png stream: header, block headers, data bytes, trailer
// depends on pngse_pkg
module pngse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pngse_pkg::status_t  status,
  output pngse_pkg::cmd_t     cmd
);

  pngse_pkg::state_t state_r, state_nxt;
  logic [pngse_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic started_r, started_nxt;
  logic is_filt_r, is_filt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pngse_pkg::S_IDLE;
      idx_r     <= '0;
      started_r <= 1'b0;
      is_filt_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
      is_filt_r <= is_filt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    is_filt_nxt = is_filt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.src     = pngse_pkg::SRC_HDR;
    cmd.idx     = idx_r;
    unique case (state_r)
      pngse_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          state_nxt = started_r ? pngse_pkg::S_SEL : pngse_pkg::S_CALC0;
        end
      end
      pngse_pkg::S_CALC0: begin
        cmd.load_geom = 1'b1;
        state_nxt = pngse_pkg::S_CALC1;
      end
      pngse_pkg::S_CALC1: begin
        cmd.calc_raw = 1'b1;
        state_nxt = pngse_pkg::S_CALC2;
      end
      pngse_pkg::S_CALC2: begin
        cmd.calc_blocks = 1'b1;
        state_nxt = pngse_pkg::S_CALC3;
      end
      pngse_pkg::S_CALC3: begin
        cmd.calc_len = 1'b1;
        started_nxt = 1'b1;
        idx_nxt = '0;
        state_nxt = pngse_pkg::S_HDR;
      end
      pngse_pkg::S_HDR: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == pngse_pkg::HdrLast) begin
            idx_nxt = '0;
            state_nxt = pngse_pkg::S_SEL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      pngse_pkg::S_SEL: begin
        // a new row opens with its filter byte
        is_filt_nxt = status.col_zero;
        idx_nxt = '0;
        state_nxt = status.blk_zero ? pngse_pkg::S_BLK : pngse_pkg::S_DATA;
      end
      pngse_pkg::S_SELP: begin
        is_filt_nxt = 1'b0;
        idx_nxt = '0;
        state_nxt = status.blk_zero ? pngse_pkg::S_BLK : pngse_pkg::S_DATA;
      end
      pngse_pkg::S_BLK: begin
        cmd.src = pngse_pkg::SRC_BLK;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == pngse_pkg::BlkLast) begin
            idx_nxt = '0;
            state_nxt = pngse_pkg::S_DATA;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      pngse_pkg::S_DATA: begin
        cmd.src = is_filt_r ? pngse_pkg::SRC_FILT : pngse_pkg::SRC_PIX;
        cmd.last = !is_filt_r && !status.last_pixel;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          idx_nxt = '0;
          if (is_filt_r) begin
            state_nxt = pngse_pkg::S_SELP;
          end else if (status.last_pixel) begin
            state_nxt = pngse_pkg::S_TRL;
          end else begin
            state_nxt = pngse_pkg::S_IDLE;
          end
        end
      end
      pngse_pkg::S_TRL: begin
        cmd.src = pngse_pkg::SRC_TRL;
        cmd.last = (idx_r == pngse_pkg::TrlLast);
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (idx_r == pngse_pkg::TrlLast) begin
            idx_nxt = '0;
            started_nxt = 1'b0;
            state_nxt = pngse_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = pngse_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/pngse_dp.sv =====
// datapath: config registers, geometry, counters, crc-32, adler-32, output word
// depends on pngse_pkg
module pngse_dp #(
  parameter int MAX_WIDTH  = pngse_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = pngse_pkg::DefMaxHeight
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [pngse_pkg::DimW-1:0]  cfg_data,
  input  logic [7:0]                  in_pixel_byte,
  input  pngse_pkg::cmd_t             cmd,
  output pngse_pkg::status_t          status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_run_end,
  output logic                        out_file_end
);

  localparam int DimW = pngse_pkg::DimW;
  localparam int ColW = pngse_pkg::ColW;
  localparam int RawW = pngse_pkg::RawW;

  logic [DimW-1:0] cfg_w_r, cfg_h_r;
  logic            cfg_a_r;
  logic [DimW-1:0] cur_w_r, cur_h_r;
  logic            cur_a_r;
  logic [ColW-1:0] row_bytes_r;
  logic [RawW-1:0] raw_r, raw_rem_r;
  logic [pngse_pkg::BlkCntW-1:0] blocks_r;
  logic [31:0]     idat_len_r;
  logic [15:0]     blk_rem_r;
  logic [ColW-1:0] col_r;
  logic [DimW-1:0] row_r;
  logic [31:0]     crc_r;
  logic [15:0]     adl_lo_r, adl_hi_r;
  logic [7:0]      pix_r;
  logic            out_valid_r, out_run_end_r, out_file_end_r;
  logic [7:0]      out_byte_r;

  logic [7:0]  byte_val;
  logic        crc_en, crc_init, is_data;
  logic [31:0] crc_base, crc_res;
  logic [31:0] adler_word;
  logic        bfinal;
  logic [15:0] blk_n;
  logic [16:0] lo_sum, lo_new, hi_sum;
  logic [15:0] hi_new;
  logic [DimW-1:0] w_clamp, h_clamp;
  logic [RawW-1:0] q0;
  logic [16:0] rsum, radj;
  logic [pngse_pkg::BlkCntW-1:0] qadj;
  logic [31:0] crc_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= pngse_pkg::RstWidth;
      cfg_h_r <= pngse_pkg::RstHeight;
      cfg_a_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pngse_pkg::RegWidth:  cfg_w_r <= cfg_data;
        pngse_pkg::RegHeight: cfg_h_r <= cfg_data;
        pngse_pkg::RegAlpha:  cfg_a_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_r == '0) w_clamp = DimW'(1);
    else if (int'(cfg_w_r) > MAX_WIDTH) w_clamp = DimW'(MAX_WIDTH);
    else w_clamp = cfg_w_r;
    if (cfg_h_r == '0) h_clamp = DimW'(1);
    else if (int'(cfg_h_r) > MAX_HEIGHT) h_clamp = DimW'(MAX_HEIGHT);
    else h_clamp = cfg_h_r;
  end

  // ceil(raw / 65535) via raw = q0 * 65536 + lo = q0 * 65535 + (lo + q0)
  always_comb begin
    q0   = raw_r >> 16;
    rsum = {1'b0, raw_r[15:0]} + 17'(q0);
    qadj = pngse_pkg::BlkCntW'(q0);
    radj = rsum;
    if (rsum >= pngse_pkg::BlockMax) begin
      qadj = qadj + 1'b1;
      radj = rsum - pngse_pkg::BlockMax;
    end
    if (radj != '0) qadj = qadj + 1'b1;
  end

  // geometry and length setup
  always_ff @(posedge clk) begin
    if (cmd.load_geom) begin
      cur_w_r <= w_clamp;
      cur_h_r <= h_clamp;
      cur_a_r <= cfg_a_r;
      row_bytes_r <= cfg_a_r ? {w_clamp, 2'b00}
                             : ({1'b0, w_clamp, 1'b0} + {2'b00, w_clamp});
    end
    if (cmd.calc_raw) begin
      raw_r <= RawW'(cur_h_r) * RawW'({1'b0, row_bytes_r} + 16'd1);
    end
    if (cmd.calc_blocks) begin
      blocks_r <= qadj;
    end
    if (cmd.calc_len) begin
      idat_len_r <= 32'(raw_r) + 32'd6 + {16'd0, blocks_r, 2'b00} + {18'd0, blocks_r};
    end
    if (cmd.load_pix) begin
      pix_r <= in_pixel_byte;
    end
  end

  assign bfinal = (raw_rem_r <= RawW'(pngse_pkg::BlockMax));
  assign blk_n  = bfinal ? raw_rem_r[15:0] : 16'hFFFF;
  assign adler_word = {adl_hi_r, adl_lo_r};
  assign crc_out = crc_r ^ pngse_pkg::Ones32;

  // byte to send and its crc treatment
  always_comb begin
    byte_val = 8'h00;
    crc_en   = 1'b0;
    crc_init = 1'b0;
    is_data  = 1'b0;
    case (cmd.src)
      pngse_pkg::SRC_HDR: begin
        crc_en   = (cmd.idx >= 6'd12 && cmd.idx <= 6'd28) || cmd.idx >= 6'd37;
        crc_init = (cmd.idx == 6'd12) || (cmd.idx == 6'd37);
        case (cmd.idx)
          6'd0:  byte_val = 8'h89;
          6'd1:  byte_val = 8'h50;
          6'd2:  byte_val = 8'h4E;
          6'd3:  byte_val = 8'h47;
          6'd4:  byte_val = 8'h0D;
          6'd5:  byte_val = 8'h0A;
          6'd6:  byte_val = 8'h1A;
          6'd7:  byte_val = 8'h0A;
          6'd11: byte_val = 8'd13;
          6'd12: byte_val = 8'h49;
          6'd13: byte_val = 8'h48;
          6'd14: byte_val = 8'h44;
          6'd15: byte_val = 8'h52;
          6'd18: byte_val = {3'd0, cur_w_r[12:8]};
          6'd19: byte_val = cur_w_r[7:0];
          6'd22: byte_val = {3'd0, cur_h_r[12:8]};
          6'd23: byte_val = cur_h_r[7:0];
          6'd24: byte_val = 8'd8;
          6'd25: byte_val = cur_a_r ? 8'd6 : 8'd2;
          6'd29: byte_val = crc_out[31:24];
          6'd30: byte_val = crc_out[23:16];
          6'd31: byte_val = crc_out[15:8];
          6'd32: byte_val = crc_out[7:0];
          6'd33: byte_val = idat_len_r[31:24];
          6'd34: byte_val = idat_len_r[23:16];
          6'd35: byte_val = idat_len_r[15:8];
          6'd36: byte_val = idat_len_r[7:0];
          6'd37: byte_val = 8'h49;
          6'd38: byte_val = 8'h44;
          6'd39: byte_val = 8'h41;
          6'd40: byte_val = 8'h54;
          6'd41: byte_val = 8'h78;
          6'd42: byte_val = 8'h01;
          default: byte_val = 8'h00;
        endcase
      end
      pngse_pkg::SRC_BLK: begin
        crc_en = 1'b1;
        case (cmd.idx)
          6'd0:    byte_val = {7'd0, bfinal};
          6'd1:    byte_val = blk_n[7:0];
          6'd2:    byte_val = blk_n[15:8];
          6'd3:    byte_val = ~blk_n[7:0];
          default: byte_val = ~blk_n[15:8];
        endcase
      end
      pngse_pkg::SRC_FILT: begin
        crc_en  = 1'b1;
        is_data = 1'b1;
      end
      pngse_pkg::SRC_PIX: begin
        crc_en   = 1'b1;
        is_data  = 1'b1;
        byte_val = pix_r;
      end
      pngse_pkg::SRC_TRL: begin
        crc_en   = cmd.idx <= 6'd3 || (cmd.idx >= 6'd12 && cmd.idx <= 6'd15);
        crc_init = (cmd.idx == 6'd12);
        case (cmd.idx)
          6'd0:  byte_val = adler_word[31:24];
          6'd1:  byte_val = adler_word[23:16];
          6'd2:  byte_val = adler_word[15:8];
          6'd3:  byte_val = adler_word[7:0];
          6'd4:  byte_val = crc_out[31:24];
          6'd5:  byte_val = crc_out[23:16];
          6'd6:  byte_val = crc_out[15:8];
          6'd7:  byte_val = crc_out[7:0];
          6'd12: byte_val = 8'h49;
          6'd13: byte_val = 8'h45;
          6'd14: byte_val = 8'h4E;
          6'd15: byte_val = 8'h44;
          6'd16: byte_val = crc_out[31:24];
          6'd17: byte_val = crc_out[23:16];
          6'd18: byte_val = crc_out[15:8];
          6'd19: byte_val = crc_out[7:0];
          default: byte_val = 8'h00;
        endcase
      end
      default: byte_val = 8'h00;
    endcase
  end

  assign crc_base = crc_init ? pngse_pkg::Ones32 : crc_r;
  assign crc_res  = pngse_pkg::crc_byte(crc_base, byte_val);

  always_comb begin
    lo_sum = {1'b0, adl_lo_r} + {9'd0, byte_val};
    lo_new = (lo_sum >= pngse_pkg::AdlerMod) ? lo_sum - pngse_pkg::AdlerMod : lo_sum;
    hi_sum = {1'b0, adl_hi_r} + lo_new;
    hi_new = (hi_sum >= pngse_pkg::AdlerMod) ? 16'(hi_sum - pngse_pkg::AdlerMod)
                                             : hi_sum[15:0];
  end

  // running state of the stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= pngse_pkg::Ones32;
      adl_lo_r  <= 16'd1;
      adl_hi_r  <= 16'd0;
      blk_rem_r <= '0;
      raw_rem_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (cmd.calc_len) begin
      adl_lo_r  <= 16'd1;
      adl_hi_r  <= 16'd0;
      blk_rem_r <= '0;
      raw_rem_r <= raw_r;
      col_r     <= '0;
      row_r     <= '0;
    end else if (cmd.emit) begin
      if (crc_en) crc_r <= crc_res;
      if (cmd.src == pngse_pkg::SRC_BLK && cmd.idx == pngse_pkg::BlkLast) begin
        blk_rem_r <= blk_n;
      end
      if (is_data) begin
        adl_lo_r <= lo_new[15:0];
        adl_hi_r <= hi_new;
        if (blk_rem_r != '0) blk_rem_r <= blk_rem_r - 1'b1;
        if (raw_rem_r != '0) raw_rem_r <= raw_rem_r - 1'b1;
      end
      if (cmd.src == pngse_pkg::SRC_PIX) begin
        if (status.last_pixel) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_r + 1'b1 == row_bytes_r) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r     <= byte_val;
      out_run_end_r  <= cmd.last;
      out_file_end_r <= (cmd.src == pngse_pkg::SRC_TRL) && (cmd.idx == pngse_pkg::TrlLast);
    end
  end

  assign status.out_free   = !out_valid_r || out_ready;
  assign status.blk_zero   = (blk_rem_r == '0);
  assign status.col_zero   = (col_r == '0);
  assign status.last_pixel = (col_r + 1'b1 == row_bytes_r) && (row_r + 1'b1 == cur_h_r);

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_end  = out_run_end_r;
  assign out_file_end = out_file_end_r;

endmodule

// ===== rtl/pngse_checker.sv =====
// port-level checks for png_stored_stream_encoder, attached by bind
// depends on the top level's ports only
module pngse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_end,
  input logic       out_file_end
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_end))
    else $error("output word changed while stalled");

  a_file_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_file_end |-> out_run_end)
    else $error("file end without run end");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind png_stored_stream_encoder pngse_checker u_pngse_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_run_end  (out_run_end),
  .out_file_end (out_file_end)
);
